// ===== hdl/msl_pkg.sv =====
`default_nettype none
package msl_pkg;

	localparam int MAX_WIDTH  = 640;
	localparam int MAX_HEIGHT = 480;
	localparam int AREA       = MAX_WIDTH * MAX_HEIGHT;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W  = $clog2(AREA);
	localparam int GEN_W  = $clog2(2 * AREA);
	localparam int LUMA_W = 11;

	localparam logic [GEN_W-1:0] GEN_OFS = GEN_W'(AREA);

	// register indexes (byte address bits 3:2)
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD    = 2'd2;

	localparam logic [9:0] WIDTH_RESET  = 10'd640;
	localparam logic [8:0] HEIGHT_RESET = 9'd480;
	localparam logic [7:0] THRESH_RESET = 8'd40;

	// one accepted pixel in the input stage
	typedef struct packed {
		logic             valid;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [COL_W-1:0] cx;
		logic [ROW_W-1:0] cy;
		logic             sel;
		logic             first;
	} msl_pix_t;

	// seeded 3x3 window and the four candidate source pixels
	typedef struct packed {
		logic             valid;
		logic [8:0]       win;
		logic [3:0][23:0] src;
		logic [COL_W-1:0] cx;
		logic [ROW_W-1:0] cy;
		logic             sel;
	} msl_win_t;

	// write into the new cell generation
	typedef struct packed {
		logic             we;
		logic [GEN_W-1:0] addr;
		logic             data;
	} msl_cwr_t;

	function automatic logic [POS_W-1:0] pix_pos(logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
		return POS_W'(int'(y) * MAX_WIDTH + int'(x));
	endfunction

	function automatic logic [3:0] count9(logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/msl_ram.sv =====
`default_nettype none
module msl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msl_seed.sv =====
`default_nettype none
module msl_seed import msl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire msl_pix_t   pix_s1,
	input  wire logic [7:0] thresh,
	input  wire msl_cwr_t   cwr,
	output msl_win_t        win_s3
);

	msl_pix_t            pix_s2;
	logic [LUMA_W-1:0]   luma_s1, luma_s2;
	logic [LUMA_W-1:0]   bg_rd, bg_v, diff, t7;
	logic [1:0]          mark_rd, seed_rd;
	logic [47:0]         src_rd, src_wr;
	logic                cell_rd;
	logic [COL_W-1:0]    seed_raddr, seed_waddr;
	logic [GEN_W-1:0]    cell_raddr;
	logic                mark, inter, filt, prev, seed, wr_en, seed_we;
	logic [2:0]          mcol, scol;
	logic [2:0]          m_c0_q, m_c1_q, s_c0_q, s_c1_q;
	logic [47:0]         p_c1_q, p_c2_q;

	assign luma_s1 = LUMA_W'({pix_s1.red, 1'b0}) + LUMA_W'({pix_s1.green, 2'b00})
		+ LUMA_W'(pix_s1.blue);
	assign t7 = LUMA_W'({thresh, 3'b000}) - LUMA_W'(thresh);

	// read addresses come from the input stage
	assign seed_raddr = (pix_s1.cx == '0) ? '0 : pix_s1.cx - COL_W'(1);
	always_comb begin
		cell_raddr = '0;
		if (pix_s1.cx != '0 && pix_s1.cy != '0) begin
			cell_raddr = GEN_W'(pix_pos(pix_s1.cx - COL_W'(1), pix_s1.cy - ROW_W'(1)))
				+ (pix_s1.sel ? GEN_OFS : '0);
		end
	end

	// motion mark, 3x3 vote and seeding
	always_comb begin
		bg_v  = pix_s2.first ? '0 : bg_rd;
		diff  = (luma_s2 > bg_v) ? luma_s2 - bg_v : bg_v - luma_s2;
		mark  = diff > t7;
		mcol  = {mark, mark_rd};
		inter = pix_s2.cx >= COL_W'(2) && pix_s2.cy >= ROW_W'(2);
		filt  = inter && (count9({m_c0_q, m_c1_q, mcol}) >= 4'd4);
		prev  = inter && !pix_s2.first && cell_rd;
		seed  = prev | filt;
		scol  = {seed, seed_rd};
		src_wr = {pix_s2.red, pix_s2.green, pix_s2.blue, src_rd[47:24]};
	end

	assign wr_en      = adv && pix_s2.valid;
	assign seed_we    = wr_en && pix_s2.cx != '0;
	assign seed_waddr = pix_s2.cx - COL_W'(1);

	msl_ram #(.WIDTH(LUMA_W), .DEPTH(AREA)) u_bg (
		.clk(clk), .we(wr_en), .waddr(pix_pos(pix_s2.cx, pix_s2.cy)), .wdata(luma_s2),
		.re(adv), .raddr(pix_pos(pix_s1.cx, pix_s1.cy)), .rdata(bg_rd)
	);

	msl_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_mark (
		.clk(clk), .we(wr_en), .waddr(pix_s2.cx), .wdata({mark, mark_rd[1]}),
		.re(adv), .raddr(pix_s1.cx), .rdata(mark_rd)
	);

	msl_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_seed (
		.clk(clk), .we(seed_we), .waddr(seed_waddr), .wdata({seed, seed_rd[1]}),
		.re(adv), .raddr(seed_raddr), .rdata(seed_rd)
	);

	msl_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_src (
		.clk(clk), .we(wr_en), .waddr(pix_s2.cx), .wdata(src_wr),
		.re(adv), .raddr(pix_s1.cx), .rdata(src_rd)
	);

	msl_ram #(.WIDTH(1), .DEPTH(2 * AREA)) u_cell (
		.clk(clk), .we(cwr.we), .waddr(cwr.addr), .wdata(cwr.data),
		.re(adv), .raddr(cell_raddr), .rdata(cell_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
			win_s3 <= '0;
		end else if (adv) begin
			pix_s2 <= pix_s1;
			win_s3.valid <= pix_s2.valid;
			win_s3.win   <= {scol, s_c1_q, s_c0_q};
			win_s3.src   <= {p_c1_q[47:24], p_c2_q[47:24], p_c1_q[23:0], p_c2_q[23:0]};
			win_s3.cx    <= pix_s2.cx;
			win_s3.cy    <= pix_s2.cy;
			win_s3.sel   <= pix_s2.sel;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luma_s2 <= luma_s1;
		end
		// column windows slide with each pixel
		if (wr_en) begin
			m_c0_q <= m_c1_q;
			m_c1_q <= mcol;
			s_c0_q <= s_c1_q;
			s_c1_q <= scol;
			p_c2_q <= p_c1_q;
			p_c1_q <= src_rd;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msl_emit.sv =====
`default_nettype none
module msl_emit import msl_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire msl_win_t        win_s3,
	input  wire logic [WD_W-1:0] w_used,
	input  wire logic [HT_W-1:0] h_used,
	input  wire logic            result_stall,
	output logic                 adv,
	output msl_cwr_t             cwr,
	output logic                 result_valid,
	output logic [7:0]           out_red,
	output logic [7:0]           out_green,
	output logic [7:0]           out_blue,
	output logic [9:0]           pixel_column,
	output logic [8:0]           pixel_row,
	output logic                 cell_alive,
	output logic                 last_of_run
);

	function automatic logic life(logic [3:0] n, logic c);
		return (n == 4'd3) || (c && n == 4'd4);
	endfunction

	logic [3:0]       mask, pend, pick, sent_q, alive_c;
	logic [1:0]       idx;
	logic             out_free, load, last, alive;
	logic [COL_W-1:0] x;
	logic [ROW_W-1:0] y;
	logic [23:0]      src;
	logic [8:0]       w;

	logic             valid_q, alive_q, last_q;
	logic [7:0]       red_q, green_q, blue_q;
	logic [9:0]       col_q;
	logic [8:0]       row_q;

	always_comb begin
		w = win_s3.win;
		mask[0] = win_s3.cy >= ROW_W'(3) && win_s3.cx >= COL_W'(3);
		mask[1] = win_s3.cy >= ROW_W'(3) && (WD_W'(win_s3.cx) + WD_W'(1) == w_used);
		mask[2] = (HT_W'(win_s3.cy) + HT_W'(1) == h_used) && win_s3.cx >= COL_W'(3);
		mask[3] = (HT_W'(win_s3.cy) + HT_W'(1) == h_used)
			&& (WD_W'(win_s3.cx) + WD_W'(1) == w_used);
		pend = win_s3.valid ? (mask & ~sent_q) : '0;
		pick = pend & (~pend + 4'd1);
		last = (pend & (pend - 4'd1)) == '0;
		case (pick)
			4'b0010: idx = 2'd1;
			4'b0100: idx = 2'd2;
			4'b1000: idx = 2'd3;
			default: idx = 2'd0;
		endcase

		// window column beyond the right edge and row below are dead
		alive_c[0] = life(count9(w), w[4]);
		alive_c[1] = life(count9({w[8:3], 3'b000}), w[7]);
		alive_c[2] = life(count9({w[8], w[7], 1'b0, w[5], w[4], 1'b0, w[2], w[1], 1'b0}), w[5]);
		alive_c[3] = life(count9({w[8], w[7], 1'b0, w[5], w[4], 4'b0000}), w[8]);
		alive = alive_c[idx];
		src   = win_s3.src[idx];
		x = idx[0] ? win_s3.cx - COL_W'(1) : win_s3.cx - COL_W'(2);
		y = idx[1] ? win_s3.cy - ROW_W'(1) : win_s3.cy - ROW_W'(2);

		out_free = !valid_q || !result_stall;
		load     = (pend != '0) && out_free;
		adv      = (pend == '0) || (load && last);
	end

	assign cwr.we   = load;
	assign cwr.addr = GEN_W'(pix_pos(x, y)) + (win_s3.sel ? '0 : GEN_OFS);
	assign cwr.data = alive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				sent_q <= '0;
			end else if (load) begin
				sent_q <= sent_q | pick;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= alive ? 8'hff : src[23:16];
			green_q <= alive ? 8'hff : src[15:8];
			blue_q  <= alive ? 8'hff : src[7:0];
			col_q   <= 10'(x);
			row_q   <= 9'(y);
			alive_q <= alive;
			last_q  <= last;
		end
	end

	assign result_valid = valid_q;
	assign out_red      = red_q;
	assign out_green    = green_q;
	assign out_blue     = blue_q;
	assign pixel_column = col_q;
	assign pixel_row    = row_q;
	assign cell_alive   = alive_q;
	assign last_of_run  = last_q;

endmodule
`default_nettype wire

// ===== hdl/motion_seeded_life_video_effect_core.sv =====
// motion seeded life video effect core
//
// pixel channel: red/green/blue in raster order, request taken on a rising
// edge with pixel_valid high and pixel_stall low. result channel: the
// interior output pixels of the frame (out_red/green/blue, pixel_column,
// pixel_row, cell_alive, last_of_run), taken with result_valid high and
// result_stall low. apb port writes frame_width (0x0), frame_height (0x4)
// and threshold_level (0x8); pready is tied high.
//
// throughput is one pixel per cycle while the result channel does not stall,
// set by the result sequencer: the last pixel of a line (row 3 on) gives
// two results, every pixel of the last line (column 3 on) gives two, the
// last pixel of a frame gives four; the pixel channel stalls for the rest.
// a result passes pix_s1, pix_s2 and win_s3 to the output register after
// the request at (x+2, y+2), edge clamped, that completes its neighborhood.
//
// reset puts counters at column 0 row 0 and the registers at 640/480/40.
// background and cell generations read as zero for the first frame after
// reset or a size write, no clearing pass. while result_stall is high the
// output register holds; the pipeline freezes if a window has results due.
`default_nettype none
module motion_seeded_life_video_effect_core import msl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// pixel channel
	input  wire logic        pixel_valid,
	output logic             pixel_stall,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [7:0]  out_red,
	output logic      [7:0]  out_green,
	output logic      [7:0]  out_blue,
	output logic      [9:0]  pixel_column,
	output logic      [8:0]  pixel_row,
	output logic             cell_alive,
	output logic             last_of_run
);

	logic [9:0]       frame_width_q;
	logic [8:0]       frame_height_q;
	logic [7:0]       threshold_q;
	logic [WD_W-1:0]  w_used;
	logic [HT_W-1:0]  h_used;
	logic [COL_W-1:0] cx_q;
	logic [ROW_W-1:0] cy_q;
	logic             sel_q, first_q;
	logic             cfg_wr, acc, adv, last_col, last_row;
	msl_pix_t         pix_s1;
	msl_win_t         win_s3;
	msl_cwr_t         cwr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_THRESHOLD:    prdata = 32'(threshold_q);
			default:          prdata = '0;
		endcase
	end

	// frame size clamped to at least 3 and to what the stores hold
	always_comb begin
		if (frame_width_q < 10'd3) begin
			w_used = WD_W'(3);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			w_used = WD_W'(MAX_WIDTH);
		end else begin
			w_used = WD_W'(frame_width_q);
		end
		if (frame_height_q < 9'd3) begin
			h_used = HT_W'(3);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			h_used = HT_W'(MAX_HEIGHT);
		end else begin
			h_used = HT_W'(frame_height_q);
		end
	end

	assign pixel_stall = !adv;
	assign acc         = pixel_valid && adv;
	assign last_col    = WD_W'(cx_q) + WD_W'(1) >= w_used;
	assign last_row    = HT_W'(cy_q) + HT_W'(1) >= h_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			threshold_q    <= THRESH_RESET;
			cx_q           <= '0;
			cy_q           <= '0;
			sel_q          <= 1'b0;
			first_q        <= 1'b1;
			pix_s1         <= '0;
		end else begin
			if (adv) begin
				pix_s1.valid <= pixel_valid;
				pix_s1.red   <= red;
				pix_s1.green <= green;
				pix_s1.blue  <= blue;
				pix_s1.cx    <= cx_q;
				pix_s1.cy    <= cy_q;
				pix_s1.sel   <= sel_q;
				pix_s1.first <= first_q;
			end
			if (cfg_wr && (paddr[3:2] == REG_FRAME_WIDTH || paddr[3:2] == REG_FRAME_HEIGHT)) begin
				// size change restarts the frame and forgets history
				cx_q    <= '0;
				cy_q    <= '0;
				sel_q   <= 1'b0;
				first_q <= 1'b1;
			end else if (acc) begin
				if (last_col) begin
					cx_q <= '0;
					if (last_row) begin
						cy_q    <= '0;
						sel_q   <= !sel_q;
						first_q <= 1'b0;
					end else begin
						cy_q <= cy_q + ROW_W'(1);
					end
				end else begin
					cx_q <= cx_q + COL_W'(1);
				end
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_FRAME_WIDTH:  frame_width_q  <= pwdata[9:0];
					REG_FRAME_HEIGHT: frame_height_q <= pwdata[8:0];
					REG_THRESHOLD:    threshold_q    <= pwdata[7:0];
					default: ;
				endcase
			end
		end
	end

	msl_seed u_seed (
		.clk(clk), .arst_n(arst_n), .adv(adv), .pix_s1(pix_s1),
		.thresh(threshold_q), .cwr(cwr), .win_s3(win_s3)
	);

	msl_emit u_emit (
		.clk(clk), .arst_n(arst_n), .win_s3(win_s3), .w_used(w_used), .h_used(h_used),
		.result_stall(result_stall), .adv(adv), .cwr(cwr),
		.result_valid(result_valid), .out_red(out_red), .out_green(out_green),
		.out_blue(out_blue), .pixel_column(pixel_column), .pixel_row(pixel_row),
		.cell_alive(cell_alive), .last_of_run(last_of_run)
	);

	// raster counters stay inside the clamped frame
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WD_W'(cx_q) < w_used) && (HT_W'(cy_q) < h_used))
		else $error("raster counter outside frame");

	// a live cell is painted white
	a_alive_white: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cell_alive |-> out_red == 8'hff && out_green == 8'hff
		&& out_blue == 8'hff)
		else $error("live cell not white");

	// every cell write is matched by a result in the output register
	a_cell_result: assert property (@(posedge clk) disable iff (!arst_n)
		cwr.we |=> result_valid)
		else $error("cell written without result");

endmodule
`default_nettype wire
